// ===== rtl/core/multicart_prg_chr_bank_mapper_defines.svh =====
// Assertion macros used by the checker file of the bank mapper.
`ifndef MULTICART_PRG_CHR_BANK_MAPPER_DEFINES_SVH
`define MULTICART_PRG_CHR_BANK_MAPPER_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define MCM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mapper check failed: %m");

// Next-cycle implication, off while reset is high.
`define MCM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mapper check failed: %m");

`endif

// ===== rtl/core/mcm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mcm_pkg;

  // Fixed field widths of the request and result
  localparam int ADDR_W   = 16;
  localparam int DATA_W   = 8;
  localparam int PRG_W    = 8;
  localparam int CHR_W    = 7;
  localparam int MIR_W    = 2;
  localparam int TYPE_W   = 4;
  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 4;

  // Defaults for the module parameters
  localparam int PRG_BANK_BITS_DEF = 8;
  localparam int CHR_BANK_BITS_DEF = 7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAPPER_TYPE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTER_SHIFT = 1'b1;

  // Request kinds carried on tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_RESET = 1'b1;

  // Supported mapper types; writes under other codes are not taken
  typedef enum logic [TYPE_W-1:0] {
    MT_57  = 4'd0,
    MT_58  = 4'd1,
    MT_61  = 4'd2,
    MT_62  = 4'd3,
    MT_174 = 4'd4,
    MT_202 = 4'd5,
    MT_212 = 4'd6,
    MT_226 = 4'd7,
    MT_229 = 4'd8,
    MT_235 = 4'd9
  } mcm_type_e;

  typedef enum logic [MIR_W-1:0] {
    MIR_VERT      = 2'd0,
    MIR_HORZ      = 2'd1,
    MIR_SINGLE_LO = 2'd2
  } mcm_mirror_e;

  typedef struct packed {
    mcm_type_e mtype;
    logic      outer_shift;
  } mcm_cfg_t;

  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } mcm_item_t;

  // Mapper registers, at full field width
  typedef struct packed {
    logic              sixteen_k;
    logic [PRG_W-1:0]  sel_bank;
    logic [CHR_W-1:0]  gfx_bank;
    mcm_mirror_e       mirror;
    logic [3:0]        part_a;
    logic [2:0]        part_b;
  } mcm_state_t;

  typedef struct packed {
    logic [PRG_W-1:0] prg_low;
    logic [PRG_W-1:0] prg_high;
    logic [CHR_W-1:0] chr;
    mcm_mirror_e      mirror;
    logic             taken;
  } mcm_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/mcm_in_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mcm_in_reg (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           s_tvalid,
  output logic                          s_tready,
  input  wire [mcm_pkg::S_TDATA_W-1:0]  s_tdata,
  input  wire                           s_tuser,
  input  wire                           advance,
  output logic                          item_valid,
  output mcm_pkg::mcm_item_t            item
);
  import mcm_pkg::*;

  logic load;

  // Take a new request when empty or when the held one moves on
  assign s_tready = !item_valid || advance;
  assign load     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  // Payload: address in the low bits, data above
  always_ff @(posedge clk) begin
    if (load) begin
      item.op   <= s_tuser;
      item.addr <= s_tdata[ADDR_W-1:0];
      item.data <= s_tdata[ADDR_W+DATA_W-1:ADDR_W];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mcm_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mcm_decode #(
  parameter int PRG_BANK_BITS = mcm_pkg::PRG_BANK_BITS_DEF,
  parameter int CHR_BANK_BITS = mcm_pkg::CHR_BANK_BITS_DEF
) (
  input  mcm_pkg::mcm_cfg_t    cfg,
  input  mcm_pkg::mcm_item_t   item,
  input  mcm_pkg::mcm_state_t  cur,
  output mcm_pkg::mcm_state_t  nxt,
  output mcm_pkg::mcm_result_t res
);
  import mcm_pkg::*;

  localparam logic [PRG_W-1:0] PRG_MASK = PRG_W'((1 << PRG_BANK_BITS) - 1);
  localparam logic [CHR_W-1:0] CHR_MASK = CHR_W'((1 << CHR_BANK_BITS) - 1);

  // Next register values for one request
  always_comb begin
    logic [ADDR_W-1:0] a;
    logic [DATA_W-1:0] d;
    logic [PRG_W-1:0]  outer;
    logic              taken;
    a     = item.addr;
    d     = item.data;
    outer = '0;
    taken = 1'b0;
    nxt   = cur;

    if (item.op == OP_RESET) begin
      nxt.sixteen_k = (cfg.mtype == MT_57) || (cfg.mtype == MT_174);
      nxt.sel_bank  = '0;
      nxt.gfx_bank  = '0;
      nxt.mirror    = (cfg.mtype == MT_226) ? MIR_HORZ : MIR_VERT;
      nxt.part_a    = '0;
      nxt.part_b    = '0;
      taken         = 1'b1;
    end else if (a[15]) begin
      taken = 1'b1;
      case (cfg.mtype)
        MT_57: begin
          // A11 low writes graphics part a, high writes everything else
          if (!a[11]) begin
            nxt.part_a = {d[6], d[2:0]};
          end else begin
            nxt.sixteen_k = !d[4];
            nxt.sel_bank  = {5'b0, d[7:5]};
            nxt.part_b    = d[2:0];
            nxt.mirror    = d[3] ? MIR_HORZ : MIR_VERT;
          end
          nxt.gfx_bank = {3'b0, nxt.part_a | {1'b0, nxt.part_b}};
        end
        MT_58: begin
          nxt.sixteen_k = a[6];
          nxt.sel_bank  = {5'b0, a[2:0]};
          nxt.gfx_bank  = {4'b0, a[5:3]};
          nxt.mirror    = a[7] ? MIR_HORZ : MIR_VERT;
        end
        MT_61: begin
          nxt.sixteen_k = a[4];
          nxt.sel_bank  = {3'b0, a[3:0], a[5]};
          nxt.mirror    = a[7] ? MIR_HORZ : MIR_VERT;
        end
        MT_62: begin
          nxt.sixteen_k = a[5];
          nxt.sel_bank  = {1'b0, a[6], a[13:8]};
          nxt.gfx_bank  = {a[4:0], d[1:0]};
          nxt.mirror    = a[7] ? MIR_HORZ : MIR_VERT;
        end
        MT_174: begin
          nxt.sixteen_k = !a[7];
          nxt.sel_bank  = {5'b0, a[6:4]};
          nxt.gfx_bank  = {4'b0, a[3:1]};
          nxt.mirror    = a[0] ? MIR_HORZ : MIR_VERT;
        end
        MT_202: begin
          nxt.sixteen_k = !(a[0] && a[3]);
          nxt.sel_bank  = {5'b0, a[3:1]};
          nxt.gfx_bank  = {4'b0, a[3:1]};
          nxt.mirror    = a[0] ? MIR_HORZ : MIR_VERT;
        end
        MT_212: begin
          nxt.sixteen_k = !a[14];
          nxt.sel_bank  = {5'b0, a[2:0]};
          nxt.gfx_bank  = {4'b0, a[2:0]};
          nxt.mirror    = a[3] ? MIR_HORZ : MIR_VERT;
        end
        MT_226: begin
          // Even address: low bank bits, mode, mirroring; odd: bank bit 6
          if (!a[0]) begin
            nxt.sixteen_k = d[5];
            nxt.sel_bank  = {1'b0, cur.sel_bank[6], d[7], d[4:0]};
            nxt.mirror    = d[6] ? MIR_VERT : MIR_HORZ;
          end else begin
            nxt.sel_bank  = {1'b0, d[0], cur.sel_bank[5:0]};
          end
        end
        MT_229: begin
          nxt.sixteen_k = (a[4:1] != 4'b0);
          nxt.sel_bank  = {3'b0, a[4:0]};
          nxt.gfx_bank  = {2'b0, a[4:0]};
          nxt.mirror    = a[5] ? MIR_HORZ : MIR_VERT;
        end
        MT_235: begin
          // Outer bits A8..A9 land at bank bits 7..6 or bits 6..5
          outer = cfg.outer_shift ? {a[9:8], 6'b0} : {1'b0, a[9:8], 5'b0};
          nxt.sixteen_k = a[11];
          nxt.sel_bank  = {2'b0, a[4:0], a[11] && a[12]} | outer;
          if (a[10]) begin
            nxt.mirror = MIR_SINGLE_LO;
          end else if (a[13]) begin
            nxt.mirror = MIR_HORZ;
          end else begin
            nxt.mirror = MIR_VERT;
          end
        end
        default: begin
          taken = 1'b0;
        end
      endcase
    end

    nxt.sel_bank = nxt.sel_bank & PRG_MASK;
    nxt.gfx_bank = nxt.gfx_bank & CHR_MASK;

    // 32K mode: even bank low, odd bank high
    if (nxt.sixteen_k) begin
      res.prg_low  = nxt.sel_bank;
      res.prg_high = nxt.sel_bank;
    end else begin
      res.prg_low  = {nxt.sel_bank[PRG_W-1:1], 1'b0} & PRG_MASK;
      res.prg_high = {nxt.sel_bank[PRG_W-1:1], 1'b1} & PRG_MASK;
    end
    res.chr    = nxt.gfx_bank;
    res.mirror = nxt.mirror;
    res.taken  = taken;
  end

endmodule

`default_nettype wire

// ===== rtl/core/multicart_prg_chr_bank_mapper.sv =====
// A request accepted into the input register passes the decode and is
// registered on m_tdata once the result register is free. Throughput: one
// request per cycle while the result is not stalled; the single decode stage
// between the two registers sets it; a free result register lets a new one in.
// Reset (rst, synchronous): no request held, mapper type 57, outer shift 0,
// bank registers at the type 57 defaults.
`timescale 1ns / 1ps
`default_nettype none

module multicart_prg_chr_bank_mapper #(
  parameter int PRG_BANK_BITS = mcm_pkg::PRG_BANK_BITS_DEF,
  parameter int CHR_BANK_BITS = mcm_pkg::CHR_BANK_BITS_DEF
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           s_tvalid,
  output logic                          s_tready,
  // bus_address [15:0], bus_data [23:16]
  input  wire [mcm_pkg::S_TDATA_W-1:0]  s_tdata,
  // opcode [0]
  input  wire [0:0]                     s_tuser,
  output logic                          m_tvalid,
  input  wire                           m_tready,
  // prg_low_bank [7:0], prg_high_bank [15:8], chr_bank [22:16],
  // mirror_mode [24:23], write_taken [25], zero [31:26]
  output logic [mcm_pkg::M_TDATA_W-1:0] m_tdata,
  input  wire                           cfg_we,
  input  wire [mcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [mcm_pkg::CFG_DAT_W-1:0]  cfg_data
);
  import mcm_pkg::*;

  logic        advance;
  logic        item_valid;
  mcm_item_t   item;
  mcm_cfg_t    cfg;
  mcm_state_t  cur;
  mcm_state_t  nxt;
  mcm_result_t res;

  logic                     sixteen_k;
  logic [PRG_BANK_BITS-1:0] sel_bank;
  logic [CHR_BANK_BITS-1:0] gfx_bank;
  mcm_mirror_e              mirror;
  logic [3:0]               part_a;
  logic [2:0]               part_b;

  // Held request moves into the result register when that is free
  assign advance = item_valid && (!m_tvalid || m_tready);

  mcm_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser[0]),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mtype       <= MT_57;
      cfg.outer_shift <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAPPER_TYPE: cfg.mtype       <= mcm_type_e'(cfg_data);
        CFG_OUTER_SHIFT: cfg.outer_shift <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cur.sixteen_k = sixteen_k;
  assign cur.sel_bank  = PRG_W'(sel_bank);
  assign cur.gfx_bank  = CHR_W'(gfx_bank);
  assign cur.mirror    = mirror;
  assign cur.part_a    = part_a;
  assign cur.part_b    = part_b;

  mcm_decode #(
    .PRG_BANK_BITS (PRG_BANK_BITS),
    .CHR_BANK_BITS (CHR_BANK_BITS)
  ) u_decode (
    .cfg  (cfg),
    .item (item),
    .cur  (cur),
    .nxt  (nxt),
    .res  (res)
  );

  // Mapper registers, updated as each request passes the decode
  always_ff @(posedge clk) begin
    if (rst) begin
      sixteen_k <= 1'b1;
      sel_bank  <= '0;
      gfx_bank  <= '0;
      mirror    <= MIR_VERT;
      part_a    <= '0;
      part_b    <= '0;
    end else if (advance) begin
      sixteen_k <= nxt.sixteen_k;
      sel_bank  <= nxt.sel_bank[PRG_BANK_BITS-1:0];
      gfx_bank  <= nxt.gfx_bank[CHR_BANK_BITS-1:0];
      mirror    <= nxt.mirror;
      part_a    <= nxt.part_a;
      part_b    <= nxt.part_b;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {6'b0, res.taken, res.mirror, res.chr, res.prg_high, res.prg_low};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mcm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "multicart_prg_chr_bank_mapper_defines.svh"

module mcm_checker (
  input wire                           clk,
  input wire                           rst,
  input wire                           m_tvalid,
  input wire                           m_tready,
  input wire [mcm_pkg::M_TDATA_W-1:0]  m_tdata
);
  import mcm_pkg::*;

  logic bank_pair_ok;

  // Same bank in both windows, or an even bank low and its odd partner high
  assign bank_pair_ok = (m_tdata[15:8] == m_tdata[7:0]) ||
                        (m_tdata[15:9] == m_tdata[7:1] && m_tdata[8] && !m_tdata[0]);

  // A stalled result holds
  `MCM_ASSERT_NEXT(a_stall_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // Both windows show one bank, or an even/odd pair
  `MCM_ASSERT_NOW(a_bank_pair, clk, rst, m_tvalid, bank_pair_ok)

  // Mirroring code three is never produced
  `MCM_ASSERT_NOW(a_mirror_code, clk, rst, m_tvalid, !(m_tdata[24] && m_tdata[23]))

  // Padding above the fields stays zero
  `MCM_ASSERT_NOW(a_pad_zero, clk, rst, m_tvalid, m_tdata[31:26] == 6'b0)

endmodule

bind multicart_prg_chr_bank_mapper mcm_checker u_mcm_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
